// File: design/ddo_pkg.sv
// Shared types, constants and angle table for the differential-drive odometry block.
`default_nettype none
package ddo_pkg;

  localparam int DEF_COUNT_BITS   = 32;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_N           = 24;

  // register indexes on the config port
  localparam logic [1:0] CFG_MPT = 2'd0;
  localparam logic [1:0] CFG_APT = 2'd1;
  localparam logic [1:0] CFG_LIM = 2'd2;

  localparam logic [23:0] MPT_RST = 24'd6678;
  localparam logic [23:0] APT_RST = 24'd1000000;
  localparam logic [15:0] LIM_RST = 16'd500;

  // CORDIC start value: 1/gain in Q.28
  localparam logic signed [31:0] TRIG_GAIN = 32'sd163008219;
  // 10^6 / 64, the rest of the scale folds into the divisor shifts
  localparam logic signed [18:0] VEL_SCALE = 19'sd15625;

  localparam int NUM_W = 56;
  localparam int DEN_W = 34;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/ddo_div.sv
// Restoring serial divider, one quotient bit per cycle, signed saturating result.
`default_nettype none
module ddo_div
  import ddo_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic             neg_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= req_i.den;
        quo_q  <= req_i.num;
        neg_q  <= req_i.neg;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // saturate magnitude to the signed 32-bit range
  always_comb begin
    rsp_o.done = done_q;
    if (!neg_q) begin
      rsp_o.quot = (quo_q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
    end else begin
      rsp_o.quot = (quo_q > NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(req_i.start, 1) == 1'b0) else $error("done held");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");

endmodule
`default_nettype wire

// File: design/diff_drive_odometry_unit.sv
// Differential-drive odometry: pose update from wheel encoder samples.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | left_count, right_count, elapsed_us
//  out     | source    | out_valid/out_stall| pos_x, pos_y, heading, linear_vel,
//          |           |                    | angular_vel, rejected
//  cfg     | sink      | cfg_valid/ready    | cfg_index, cfg_data
//
// An accepted sample passes the delta check, 4 multiply steps, CORDIC_STEPS rotations (at
// most ATAN_N), 6 multiply/accumulate steps, then two serial divisions (56 quotient bits
// each) for the velocities, and then reaches its result beat. A rejected sample goes to the
// result beat right after the check; zero elapsed time skips the divisions. The next sample
// is taken the cycle after the beat.
// Reset clears pose, stored counts and loads the default registers.
// in_stall_o is high from acceptance until the result beat is taken.
`default_nettype none
module diff_drive_odometry_unit
  import ddo_pkg::*;
#(
  parameter int COUNT_BITS   = DEF_COUNT_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] left_count_i,
  input  wire logic [31:0] right_count_i,
  input  wire logic [23:0] elapsed_us_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      heading_o,
  output logic [31:0]      linear_vel_o,
  output logic [31:0]      angular_vel_o,
  output logic             rejected_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int CORD_N = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_MSUM = 4'd2;
  localparam logic [3:0] S_MDTH = 4'd3;
  localparam logic [3:0] S_MLIN = 4'd4;
  localparam logic [3:0] S_MANG = 4'd5;
  localparam logic [3:0] S_CORD = 4'd6;
  localparam logic [3:0] S_MCL  = 4'd7;
  localparam logic [3:0] S_MCH  = 4'd8;
  localparam logic [3:0] S_MSL  = 4'd9;
  localparam logic [3:0] S_MSH  = 4'd10;
  localparam logic [3:0] S_YADD = 4'd11;
  localparam logic [3:0] S_YUPD = 4'd12;
  localparam logic [3:0] S_DIVL = 4'd13;
  localparam logic [3:0] S_DIVA = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic signed [63:0] RND = 64'sd268435456;

  logic [3:0]         state_q;
  logic [23:0]        mpt_q, apt_q;
  logic [15:0]        lim_q;
  logic [31:0]        left_q, right_q, prev_l_q, prev_r_q, th_q;
  logic [23:0]        us_q;
  logic signed [31:0] x_q, y_q, cx_q, cy_q, cz_q;
  logic               flip_q;
  logic [4:0]         cnt_q;
  logic signed [17:0] dl_q, dr_q;
  logic signed [41:0] sum_q, dth_q;
  logic signed [56:0] nlin_q, nang_q;
  logic signed [62:0] pr_q;
  logic signed [63:0] acc_q;
  logic [31:0]        lin_q, ang_q;
  logic               rej_q;

  // count deltas, wrapped to COUNT_BITS
  logic [31:0]                 dl_raw, dr_raw;
  logic signed [COUNT_BITS:0]  dl_w, dr_w, lim_w;
  logic                        reject;

  assign dl_raw = left_q - prev_l_q;
  assign dr_raw = right_q - prev_r_q;
  assign dl_w   = signed'({dl_raw[COUNT_BITS-1], dl_raw[COUNT_BITS-1:0]});
  assign dr_w   = signed'({dr_raw[COUNT_BITS-1], dr_raw[COUNT_BITS-1:0]});
  assign lim_w  = signed'((COUNT_BITS+1)'(lim_q));
  assign reject = (dl_w > lim_w) || (dl_w < -lim_w) || (dr_w > lim_w) || (dr_w < -lim_w);

  // fold heading into [-1/4, 1/4) turn
  logic [31:0] th_off;
  assign th_off = th_q + 32'h4000_0000;

  // CORDIC rotation step
  logic signed [31:0] xs, ys, at;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = signed'(atan_turn(cnt_q));

  logic signed [31:0] c_v, s_v;
  logic signed [33:0] m_v;
  assign c_v = flip_q ? -cx_q : cx_q;
  assign s_v = flip_q ? -cy_q : cy_q;
  assign m_v = sum_q[41:8];

  // shared multiplier
  logic signed [43:0] op_a;
  logic signed [18:0] op_b;
  logic signed [62:0] prod;
  assign prod = op_a * op_b;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_MSUM: begin
        op_a = signed'({20'd0, mpt_q});
        op_b = 19'(dl_q + dr_q);
      end
      S_MDTH: begin
        op_a = signed'({20'd0, apt_q});
        op_b = 19'(dr_q - dl_q);
      end
      S_MLIN: begin
        op_a = 44'(sum_q);
        op_b = VEL_SCALE;
      end
      S_MANG: begin
        op_a = 44'(dth_q);
        op_b = VEL_SCALE;
      end
      S_MCL: begin
        op_a = 44'(m_v);
        op_b = signed'({4'd0, c_v[14:0]});
      end
      S_MCH: begin
        op_a = 44'(m_v);
        op_b = 19'(signed'(c_v[31:15]));
      end
      S_MSL: begin
        op_a = 44'(m_v);
        op_b = signed'({4'd0, s_v[14:0]});
      end
      S_MSH: begin
        op_a = 44'(m_v);
        op_b = 19'(signed'(s_v[31:15]));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [34:0] dpos;
  logic signed [63:0] acc_add;
  logic signed [31:0] x_new, y_new;
  assign dpos    = acc_q[63:29];
  assign acc_add = acc_q + (64'(pr_q) <<< 15) + RND;
  assign x_new   = sat36(36'(x_q) + 36'(dpos));
  assign y_new   = sat36(36'(y_q) + 36'(dpos));

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [56:0] nlin_mag, nang_mag;
  assign nlin_mag = nlin_q[56] ? 57'(-nlin_q) : 57'(nlin_q);
  assign nang_mag = nang_q[56] ? 57'(-nang_q) : 57'(nang_q);

  always_comb begin
    div_req = '0;
    if (state_q == S_YUPD && us_q != 24'd0) begin
      div_req.start = 1'b1;
      div_req.neg   = nlin_q[56];
      div_req.num   = nlin_mag[NUM_W-1:0];
      div_req.den   = DEN_W'({us_q, 3'd0});
    end else if (state_q == S_DIVL && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.neg   = nang_q[56];
      div_req.num   = nang_mag[NUM_W-1:0];
      div_req.den   = {us_q, 10'd0};
    end
  end

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mpt_q    <= MPT_RST;
      apt_q    <= APT_RST;
      lim_q    <= LIM_RST;
      left_q   <= '0;
      right_q  <= '0;
      us_q     <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      th_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      flip_q   <= 1'b0;
      cnt_q    <= '0;
      dl_q     <= '0;
      dr_q     <= '0;
      sum_q    <= '0;
      dth_q    <= '0;
      nlin_q   <= '0;
      nang_q   <= '0;
      pr_q     <= '0;
      acc_q    <= '0;
      lin_q    <= '0;
      ang_q    <= '0;
      rej_q    <= 1'b0;
    end else begin
      pr_q <= prod;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MPT: mpt_q <= cfg_data_i;
          CFG_APT: apt_q <= cfg_data_i;
          CFG_LIM: lim_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            left_q  <= left_count_i;
            right_q <= right_count_i;
            us_q    <= elapsed_us_i;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          lin_q <= '0;
          ang_q <= '0;
          if (reject) begin
            prev_l_q <= '0;
            prev_r_q <= '0;
            rej_q    <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            dl_q    <= 18'(dl_w);
            dr_q    <= 18'(dr_w);
            rej_q   <= 1'b0;
            state_q <= S_MSUM;
          end
        end
        S_MSUM: begin
          flip_q  <= th_off[31];
          cz_q    <= signed'(th_off[31] ? (th_q + 32'h8000_0000) : th_q);
          cx_q    <= TRIG_GAIN;
          cy_q    <= '0;
          cnt_q   <= '0;
          state_q <= S_MDTH;
        end
        S_MDTH: begin
          sum_q   <= pr_q[41:0];
          state_q <= S_MLIN;
        end
        S_MLIN: begin
          dth_q   <= pr_q[41:0];
          state_q <= S_MANG;
        end
        S_MANG: begin
          nlin_q  <= pr_q[56:0];
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cnt_q == 5'd0) nang_q <= pr_q[56:0];
          if (!cz_q[31]) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + at;
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(CORD_N - 1)) state_q <= S_MCL;
        end
        S_MCL: state_q <= S_MCH;
        S_MCH: begin
          acc_q   <= 64'(pr_q);
          state_q <= S_MSL;
        end
        S_MSL: begin
          acc_q   <= acc_add;
          state_q <= S_MSH;
        end
        S_MSH: begin
          x_q     <= x_new;
          acc_q   <= 64'(pr_q);
          state_q <= S_YADD;
        end
        S_YADD: begin
          acc_q   <= acc_add;
          state_q <= S_YUPD;
        end
        S_YUPD: begin
          y_q      <= y_new;
          th_q     <= th_q + dth_q[31:0];
          prev_l_q <= left_q;
          prev_r_q <= right_q;
          state_q  <= (us_q != 24'd0) ? S_DIVL : S_OUT;
        end
        S_DIVL: begin
          if (div_rsp.done) begin
            lin_q   <= div_rsp.quot;
            state_q <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_rsp.done) begin
            ang_q   <= div_rsp.quot;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cfg_ready_o   = 1'b1;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign heading_o     = th_q;
  assign linear_vel_o  = lin_q;
  assign angular_vel_o = ang_q;
  assign rejected_o    = rej_q;

  a_rej_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && reject) |=> (prev_l_q == 32'd0 && prev_r_q == 32'd0 && rej_q))
    else $error("rejected sample did not clear stored counts");
  a_rej_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (linear_vel_o == 32'd0 && angular_vel_o == 32'd0))
    else $error("rejected beat carries velocity");
  a_zero_us: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && us_q == 24'd0) |-> (linear_vel_o == 32'd0 && angular_vel_o == 32'd0))
    else $error("velocity nonzero with zero elapsed time");
  a_cord_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q <= 5'(CORD_N - 1)))
    else $error("rotation counter overran");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for the differential-drive odometry unit: random and directed samples, scoreboard check.
`default_nettype none
module testbench
  import ddo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [23:0] us;
  } sample_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [31:0] lin;
    logic [31:0] ang;
    logic        rej;
  } pose_t;

  class odo_scoreboard;
    logic [23:0] mpt;
    logic [23:0] apt;
    logic [15:0] lim;
    logic [31:0] last_left;
    logic [31:0] last_right;
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] theta;
    pose_t       poses_due[$];
    int          errors;
    longint      atan_tab[24];

    function new();
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                   41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      mpt = MPT_RST;
      apt = APT_RST;
      lim = LIM_RST;
      last_left = '0;
      last_right = '0;
      x_pos = '0;
      y_pos = '0;
      theta = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_MPT: mpt = data;
        CFG_APT: apt = data;
        CFG_LIM: lim = data[15:0];
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint wheel_delta(logic [31:0] now, logic [31:0] was);
      logic [31:0] d;
      d = now - was;
      return longint'($signed(d));
    endfunction

    // cos/sin of the heading in Q.28, angle folded into +-1/4 turn first
    function void cos_sin(logic [31:0] angle, output longint c, output longint s);
      logic        flip;
      logic [31:0] a;
      longint      z, cx, cy, xs, ys;
      flip = ((angle + 32'h4000_0000) & 32'h8000_0000) != 0;
      a = flip ? angle + 32'h8000_0000 : angle;
      z = longint'($signed(a));
      cx = 163008219;
      cy = 0;
      for (int i = 0; i < DEF_CORDIC_STEPS && i < 24; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx = cx - ys;
          cy = cy + xs;
          z = z - atan_tab[i];
        end else begin
          cx = cx + ys;
          cy = cy - xs;
          z = z + atan_tab[i];
        end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
    endfunction

    function void note_sample(sample_t smp);
      longint dl, dr, lm, sum, dth, m, c, s;
      pose_t  p;
      dl = wheel_delta(smp.left, last_left);
      dr = wheel_delta(smp.right, last_right);
      lm = longint'(lim);
      p.lin = '0;
      p.ang = '0;
      p.rej = 1'b0;
      if (dl > lm || dl < -lm || dr > lm || dr < -lm) begin
        last_left = '0;
        last_right = '0;
        p.rej = 1'b1;
      end else begin
        sum = (dl + dr) * longint'(mpt);
        dth = (dr - dl) * longint'(apt);
        m = sum >>> 8;
        cos_sin(theta, c, s);
        x_pos = 32'(sat32(longint'($signed(x_pos)) + ((m * c + (64'sd1 <<< 28)) >>> 29)));
        y_pos = 32'(sat32(longint'($signed(y_pos)) + ((m * s + (64'sd1 <<< 28)) >>> 29)));
        theta = theta + dth[31:0];
        last_left = smp.left;
        last_right = smp.right;
        if (smp.us != 0) begin
          p.lin = 32'(sat32((sum * 1000000) / (longint'(smp.us) * 512)));
          p.ang = 32'(sat32((dth * 1000000) / (longint'(smp.us) * 65536)));
        end
      end
      p.x = x_pos;
      p.y = y_pos;
      p.hdg = theta;
      poses_due.push_back(p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (poses_due.size() == 0) begin
        report("unexpected beat", 32'd1, 32'd0);
        return;
      end
      want = poses_due.pop_front();
      if (got.x !== want.x) report("pos_x", got.x, want.x);
      if (got.y !== want.y) report("pos_y", got.y, want.y);
      if (got.hdg !== want.hdg) report("heading", got.hdg, want.hdg);
      if (got.lin !== want.lin) report("linear_vel", got.lin, want.lin);
      if (got.ang !== want.ang) report("angular_vel", got.ang, want.ang);
      if (got.rej !== want.rej) report("rejected", 32'(got.rej), 32'(want.rej));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] left_count = '0;
  logic [31:0] right_count = '0;
  logic [23:0] elapsed_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pos_x, pos_y, heading, linear_vel, angular_vel;
  logic        rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  odo_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_out = 1'b0;
  int  cycles = 0;

  diff_drive_odometry_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .left_count_i(left_count), .right_count_i(right_count), .elapsed_us_i(elapsed_us),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .heading_o(heading),
    .linear_vel_o(linear_vel), .angular_vel_o(angular_vel), .rejected_o(rejected),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall <= hold_out || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    pose_t got;
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && out_valid && !out_stall) begin
      got = '{pos_x, pos_y, heading, linear_vel, angular_vel, rejected};
      sb.check_pose(got);
    end
  end

  task automatic send(logic [31:0] l, logic [31:0] r, logic [23:0] us);
    sample_t smp;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    left_count = l;
    right_count = r;
    elapsed_us = us;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    smp = '{l, r, us};
    sb.note_sample(smp);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.poses_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(logic [23:0] mpt, logic [23:0] apt, logic [15:0] lim);
    write_reg(CFG_MPT, mpt);
    write_reg(CFG_APT, apt);
    write_reg(CFG_LIM, {8'd0, lim});
  endtask

  function automatic logic [31:0] step_count(logic [31:0] was, int lim);
    int d;
    d = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? lim : -lim)
                                    : int'($urandom_range(0, 2 * lim)) - lim;
    return was + 32'(d);
  endfunction

  task automatic random_samples(int n);
    int          lim, pick;
    logic [31:0] l, r;
    logic [23:0] us;
    for (int k = 0; k < n; k++) begin
      lim = int'(sb.lim);
      pick = $urandom_range(0, 99);
      l = step_count(sb.last_left, lim);
      r = step_count(sb.last_right, lim);
      if (pick < 8) begin
        l = $urandom();
        r = $urandom();
      end else if (pick < 12) begin
        // one wheel just past the jump limit
        if ($urandom_range(0, 1) != 0) l = sb.last_left + 32'(lim + 1 + $urandom_range(0, 999));
        else r = sb.last_right - 32'(lim + 1 + $urandom_range(0, 999));
      end
      pick = $urandom_range(0, 99);
      us = (pick < 10) ? 24'd0 : (pick < 20) ? 24'($urandom()) : 24'($urandom_range(1, 100000));
      send(l, r, us);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, default registers
    send(32'd0, 32'd0, 24'd0);
    send(32'd100, 32'd100, 24'd1000);
    send(32'd150, 32'd250, 24'd20000);
    send(32'd200, 32'd300, 24'd0);
    send(32'd700, 32'd300, 24'hFFFFFF);
    send(32'd700, -32'sd200, 24'd5000);
    send(32'd1201, -32'sd200, 24'd5000);
    send(-32'sd5, -32'sd3, 24'd100);
    send(32'h7FFF_FFFF, 32'd0, 24'd100);
    send(32'd0, 32'h8000_0000, 24'd100);
    send(32'hFFFF_FFFF, 32'd1, 24'd1);
    for (int k = 1; k <= 10; k++)
      send(32'(-250 * k), 32'(250 * k), 24'd1);
    drain();

    // all registers at their top, and a write to an unused index
    set_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    write_reg(2'd3, 24'($urandom()));
    send(32'd65535, 32'd65535, 24'd1);
    send(32'd0, 32'd131070, 24'd1);
    random_samples(60);
    drain();

    set_regs(24'd0, 24'd0, 16'd0);
    idle_pct = 81;
    random_samples(40);
    drain();

    set_regs(24'($urandom()), 24'($urandom()), 16'($urandom_range(1, 2000)));
    idle_pct = 0;
    stall_pct = 81;
    random_samples(100);
    drain();

    set_regs(24'($urandom()), 24'($urandom()), 16'($urandom()));
    idle_pct = 10;
    stall_pct = 10;
    random_samples(100);
    drain();

    // receiver holds off while samples keep coming
    set_regs(MPT_RST, APT_RST, LIM_RST);
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_out = 1'b0;
      end
      random_samples(30);
    join
    drain();

    set_regs(24'($urandom()), 24'($urandom()), 16'($urandom_range(0, 20)));
    random_samples(100);
    drain();

    set_regs(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    idle_pct = 10;
    stall_pct = 81;
    random_samples(100);
    drain();

    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
